// ===== rtl/core/lz77_token_decoder_macros.svh =====
// ---------------------------------------------------------------------------
// lz77_token_decoder_macros
// assertion helpers for the decoder rtl
// ---------------------------------------------------------------------------
`ifndef LZ77_TOKEN_DECODER_MACROS_SVH
`define LZ77_TOKEN_DECODER_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define LZTD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while reset is asserted
`define LZTD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/lztd_pkg.sv =====
// ---------------------------------------------------------------------------
// lztd_pkg
// shared constants and types of the lz77 token decoder
// ---------------------------------------------------------------------------
package lztd_pkg;

  // history ring, depth must be a power of two
  localparam int unsigned HIST_DEPTH = 4096;
  localparam int unsigned HIST_AW    = $clog2(HIST_DEPTH);
  localparam int unsigned CNT_W      = HIST_AW + 1;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned NIB_W  = 4;
  localparam int unsigned OFFS_W = NIB_W + BYTE_W;

  localparam logic [1:0]       HDR_BYTES = 2'd3;
  localparam logic [NIB_W-1:0] NIB_ZERO  = '0;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_TOKEN,
    PH_LITERAL,
    PH_OFFSET,
    PH_COPY_RD,
    PH_COPY_WR,
    PH_ENDED
  } phase_e;

  typedef struct packed {
    logic              push;
    logic [BYTE_W-1:0] data;
    logic              byte_valid;
    logic              last;
    logic              stream_end;
    logic              bad_offset;
  } result_t;

  typedef struct packed {
    logic               we;
    logic [HIST_AW-1:0] waddr;
    logic [BYTE_W-1:0]  wdata;
    logic               re;
    logic [HIST_AW-1:0] raddr;
  } ram_req_t;

endpackage

// ===== rtl/core/lz77_token_decoder.sv =====
// ---------------------------------------------------------------------------
// lz77_token_decoder
// byte-serial lz77 stream decoder with a 4096-byte history ring
// ---------------------------------------------------------------------------
// input channel: one compressed byte per transaction (in_valid_i / in_stall_o)
// output channel: one result per transaction (out_valid_o / out_stall_i)
// the first three bytes are a header and produce nothing, as do literal-run and match tokens
// a literal byte gives one result, registered, valid in the cycle after it is
// taken; the input keeps running at one byte per cycle unless the output stalls
// an offset byte starts a copy: each byte is read from the history ram, then
// written back and registered as a result once the output has room, and the
// input is held stalled until every byte of the match is done
// a zero or out-of-range offset gives one bad_offset result instead
// an end token gives one stream_end result; after it every byte is dropped
// while a result waits under out_stall_i the input is stalled as well
// reset clears the parser and pointers; the history ram is not cleared, and
// no unwritten entry is ever read since offsets are checked
// ---------------------------------------------------------------------------
`include "lz77_token_decoder_macros.svh"

module lz77_token_decoder import lztd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [BYTE_W-1:0] in_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [BYTE_W-1:0] out_byte_o,
  output logic              byte_valid_o,
  output logic              last_of_run_o,
  output logic              stream_end_o,
  output logic              bad_offset_o
);

  result_t           res;
  ram_req_t          req;
  logic              out_free;
  logic              ended;
  logic [BYTE_W-1:0] rdata;

  lztd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_byte_i  (in_byte_i),
    .in_stall_o (in_stall_o),
    .out_free_i (out_free),
    .rdata_i    (rdata),
    .res_o      (res),
    .req_o      (req),
    .ended_o    (ended)
  );

  lztd_ram #(
    .DEPTH (HIST_DEPTH),
    .WIDTH (BYTE_W)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (req.we),
    .waddr_i (req.waddr),
    .wdata_i (req.wdata),
    .re_i    (req.re),
    .raddr_i (req.raddr),
    .rdata_o (rdata)
  );

  lztd_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .res_i         (res),
    .out_stall_i   (out_stall_i),
    .out_free_o    (out_free),
    .out_valid_o   (out_valid_o),
    .out_byte_o    (out_byte_o),
    .byte_valid_o  (byte_valid_o),
    .last_of_run_o (last_of_run_o),
    .stream_end_o  (stream_end_o),
    .bad_offset_o  (bad_offset_o)
  );

  `LZTD_ASSERT_NOW(a_hist_write_is_byte, clk_i, rst_ni, req.we, res.push && res.byte_valid, "history write without a decoded byte")
  `LZTD_ASSERT_NOW(a_flag_ends_run, clk_i, rst_ni, out_valid_o && (stream_end_o || bad_offset_o), last_of_run_o && !byte_valid_o, "end or bad offset result not last of run")
  `LZTD_ASSERT_NEXT(a_silent_after_end, clk_i, rst_ni, ended, !res.push && !req.we, "activity after end of stream")

endmodule

// ===== rtl/core/lztd_ram.sv =====
// ---------------------------------------------------------------------------
// lztd_ram
// simple dual-port synchronous ram, registered read data
// ---------------------------------------------------------------------------
module lztd_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/lztd_ctrl.sv =====
// ---------------------------------------------------------------------------
// lztd_ctrl
// token parser and match copy sequencer around the history ram
// ---------------------------------------------------------------------------
module lztd_ctrl import lztd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [BYTE_W-1:0] in_byte_i,
  output logic              in_stall_o,
  input  logic              out_free_i,
  input  logic [BYTE_W-1:0] rdata_i,
  output result_t           res_o,
  output ram_req_t          req_o,
  output logic              ended_o
);

  phase_e             phase_q, phase_d;
  logic [1:0]         hdr_q, hdr_d;
  logic [NIB_W-1:0]   lit_q, lit_d;
  logic [NIB_W-1:0]   mlen_q, mlen_d;
  logic [NIB_W-1:0]   offh_q, offh_d;
  logic [NIB_W-1:0]   cnt_q, cnt_d;
  logic [HIST_AW-1:0] wp_q, wp_d;
  logic [HIST_AW-1:0] src_q, src_d;
  logic [CNT_W-1:0]   prod_q, prod_d;

  logic              copying;
  logic              accept;
  logic [NIB_W-1:0]  code;
  logic [NIB_W-1:0]  low;
  logic [OFFS_W-1:0] offset;
  logic              bad;
  logic              prod_full;

  assign code      = in_byte_i[BYTE_W-1:NIB_W];
  assign low       = in_byte_i[NIB_W-1:0];
  assign offset    = {offh_q, in_byte_i};
  assign bad       = (offset == '0) || (CNT_W'(offset) > prod_q);
  assign prod_full = (prod_q == CNT_W'(HIST_DEPTH));
  assign copying   = (phase_q == PH_COPY_RD) || (phase_q == PH_COPY_WR);
  assign in_stall_o = copying || !out_free_i;
  assign accept    = in_valid_i && !in_stall_o;
  assign ended_o   = (phase_q == PH_ENDED);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      hdr_q   <= HDR_BYTES;
      lit_q   <= '0;
      mlen_q  <= '0;
      offh_q  <= '0;
      cnt_q   <= '0;
      wp_q    <= '0;
      src_q   <= '0;
      prod_q  <= '0;
    end else begin
      phase_q <= phase_d;
      hdr_q   <= hdr_d;
      lit_q   <= lit_d;
      mlen_q  <= mlen_d;
      offh_q  <= offh_d;
      cnt_q   <= cnt_d;
      wp_q    <= wp_d;
      src_q   <= src_d;
      prod_q  <= prod_d;
    end
  end

  always_comb begin
    phase_d = phase_q;
    hdr_d   = hdr_q;
    lit_d   = lit_q;
    mlen_d  = mlen_q;
    offh_d  = offh_q;
    cnt_d   = cnt_q;
    wp_d    = wp_q;
    src_d   = src_q;
    prod_d  = prod_q;
    res_o   = '0;
    req_o   = '0;

    unique case (phase_q)
      PH_HEADER: begin
        if (accept) begin
          hdr_d = hdr_q - 2'd1;
          if (hdr_q == 2'd1) begin
            phase_d = PH_TOKEN;
          end
        end
      end
      PH_TOKEN: begin
        if (accept) begin
          if (code == NIB_ZERO) begin
            if (low == NIB_ZERO) begin
              phase_d          = PH_ENDED;
              res_o.push       = 1'b1;
              res_o.last       = 1'b1;
              res_o.stream_end = 1'b1;
            end else begin
              lit_d   = low;
              phase_d = PH_LITERAL;
            end
          end else begin
            mlen_d  = code;
            offh_d  = low;
            phase_d = PH_OFFSET;
          end
        end
      end
      PH_LITERAL: begin
        if (accept) begin
          res_o.push       = 1'b1;
          res_o.data       = in_byte_i;
          res_o.byte_valid = 1'b1;
          res_o.last       = 1'b1;
          req_o.we         = 1'b1;
          req_o.waddr      = wp_q;
          req_o.wdata      = in_byte_i;
          wp_d             = wp_q + 1'b1;
          if (!prod_full) begin
            prod_d = prod_q + 1'b1;
          end
          lit_d = lit_q - 1'b1;
          if (lit_q == NIB_W'(1)) begin
            phase_d = PH_TOKEN;
          end
        end
      end
      PH_OFFSET: begin
        if (accept) begin
          if (bad) begin
            res_o.push       = 1'b1;
            res_o.last       = 1'b1;
            res_o.bad_offset = 1'b1;
            phase_d          = PH_TOKEN;
          end else begin
            // ring wraps by truncation
            src_d   = wp_q - HIST_AW'(offset);
            cnt_d   = mlen_q;
            phase_d = PH_COPY_RD;
          end
        end
      end
      PH_COPY_RD: begin
        req_o.re    = 1'b1;
        req_o.raddr = src_q;
        phase_d     = PH_COPY_WR;
      end
      PH_COPY_WR: begin
        // read data holds until the output slot frees up
        if (out_free_i) begin
          res_o.push       = 1'b1;
          res_o.data       = rdata_i;
          res_o.byte_valid = 1'b1;
          res_o.last       = (cnt_q == NIB_W'(1));
          req_o.we         = 1'b1;
          req_o.waddr      = wp_q;
          req_o.wdata      = rdata_i;
          wp_d             = wp_q + 1'b1;
          src_d            = src_q + 1'b1;
          if (!prod_full) begin
            prod_d = prod_q + 1'b1;
          end
          cnt_d   = cnt_q - 1'b1;
          phase_d = (cnt_q == NIB_W'(1)) ? PH_TOKEN : PH_COPY_RD;
        end
      end
      PH_ENDED: begin
        // swallow everything until reset
      end
      default: begin
        phase_d = PH_HEADER;
      end
    endcase
  end

endmodule

// ===== rtl/core/lztd_out_stage.sv =====
// ---------------------------------------------------------------------------
// lztd_out_stage
// output register holding one result transaction
// ---------------------------------------------------------------------------
module lztd_out_stage import lztd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  result_t           res_i,
  input  logic              out_stall_i,
  output logic              out_free_o,
  output logic              out_valid_o,
  output logic [BYTE_W-1:0] out_byte_o,
  output logic              byte_valid_o,
  output logic              last_of_run_o,
  output logic              stream_end_o,
  output logic              bad_offset_o
);

  logic    valid_q, valid_d;
  result_t data_q;

  assign out_free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (res_i.push) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_i.push) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o   = valid_q;
  assign out_byte_o    = data_q.data;
  assign byte_valid_o  = data_q.byte_valid;
  assign last_of_run_o = data_q.last;
  assign stream_end_o  = data_q.stream_end;
  assign bad_offset_o  = data_q.bad_offset;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// drives a byte-serial lz77 stream into the token decoder and checks every
// result against a built-in decoder with its own history ring; covers the
// header, literal runs, overlapping and long-reach copies, rejected offsets
// and the end token, under random idling on both sides and one long hold-off
// ---------------------------------------------------------------------------
module testbench;
  import lztd_pkg::*;

  localparam int unsigned RANDOM_ITEMS   = 410;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned SETTLE_CYCLES  = 40;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned MAX_REPORTS    = 10;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              byte_valid;
    logic              last;
    logic              stream_end;
    logic              bad_offset;
  } decoded_t;

  class decode_checker;
    decoded_t           decoded_q[$];
    phase_e             phase;
    logic [1:0]         hdr_left;
    logic [NIB_W-1:0]   lit_left;
    logic [NIB_W-1:0]   copy_len;
    logic [NIB_W-1:0]   offs_hi;
    logic [BYTE_W-1:0]  ring[HIST_DEPTH];
    logic [HIST_AW-1:0] wr_ptr;
    int unsigned        produced;
    int unsigned        n_checked, n_errors, n_data, n_bad, n_end;

    function new();
      phase    = PH_HEADER;
      hdr_left = HDR_BYTES;
      lit_left = '0;
      copy_len = '0;
      offs_hi  = '0;
      wr_ptr   = '0;
      produced = 0;
    endfunction

    function void push_ring(logic [BYTE_W-1:0] b);
      ring[wr_ptr] = b;
      wr_ptr++;
      if (produced < HIST_DEPTH) produced++;
    endfunction

    // works out the results of one accepted input byte
    function void decode_byte(logic [BYTE_W-1:0] b);
      decoded_t           r;
      logic [OFFS_W-1:0]  offs;
      logic [HIST_AW-1:0] src;
      r = '0;
      case (phase)
        PH_HEADER: begin
          if (hdr_left > 0) hdr_left--;
          if (hdr_left == 0) phase = PH_TOKEN;
        end
        PH_TOKEN: begin
          if (b[7:4] == NIB_ZERO) begin
            if (b[3:0] == NIB_ZERO) begin
              phase        = PH_ENDED;
              r.last       = 1'b1;
              r.stream_end = 1'b1;
              decoded_q.push_back(r);
            end else begin
              lit_left = b[3:0];
              phase    = PH_LITERAL;
            end
          end else begin
            copy_len = b[7:4];
            offs_hi  = b[3:0];
            phase    = PH_OFFSET;
          end
        end
        PH_LITERAL: begin
          push_ring(b);
          r.data       = b;
          r.byte_valid = 1'b1;
          r.last       = 1'b1;
          decoded_q.push_back(r);
          lit_left--;
          if (lit_left == 0) phase = PH_TOKEN;
        end
        PH_OFFSET: begin
          offs  = {offs_hi, b};
          phase = PH_TOKEN;
          if (offs == 0 || offs > produced) begin
            r.last       = 1'b1;
            r.bad_offset = 1'b1;
            decoded_q.push_back(r);
          end else begin
            // one byte at a time so a copy may read what it just wrote
            src = wr_ptr - offs[HIST_AW-1:0];
            for (int c = 0; c < int'(copy_len); c++) begin
              r.data       = ring[src];
              r.byte_valid = 1'b1;
              r.last       = (c + 1 == int'(copy_len));
              push_ring(r.data);
              decoded_q.push_back(r);
              src++;
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void report(string what, decoded_t want, decoded_t got);
      n_errors++;
      if (n_errors <= MAX_REPORTS) begin
        $write("%0t %s: expected byte %02h valid %b last %b end %b bad %b",
               $time, what, want.data, want.byte_valid, want.last, want.stream_end,
               want.bad_offset);
        $display(", got byte %02h valid %b last %b end %b bad %b",
                 got.data, got.byte_valid, got.last, got.stream_end, got.bad_offset);
      end
    endfunction

    function void check_output(decoded_t got);
      decoded_t want;
      n_checked++;
      if (decoded_q.size() == 0) begin
        report("result with nothing pending", '0, got);
        return;
      end
      want = decoded_q.pop_front();
      if (want.byte_valid) n_data++;
      if (want.bad_offset) n_bad++;
      if (want.stream_end) n_end++;
      if (got.data !== want.data || got.byte_valid !== want.byte_valid ||
          got.last !== want.last || got.stream_end !== want.stream_end ||
          got.bad_offset !== want.bad_offset)
        report("result mismatch", want, got);
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [BYTE_W-1:0] in_byte_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [BYTE_W-1:0] out_byte_o;
  logic              byte_valid_o;
  logic              last_of_run_o;
  logic              stream_end_o;
  logic              bad_offset_o;

  decode_checker     sb = new();
  logic [BYTE_W-1:0] stream_q[$];
  int unsigned       stream_total;
  int unsigned       sent_count;
  int unsigned       gen_produced;
  int unsigned       quiet_cycles;
  bit                hold_done;

  lz77_token_decoder u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_byte_i     (in_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .byte_valid_o  (byte_valid_o),
    .last_of_run_o (last_of_run_o),
    .stream_end_o  (stream_end_o),
    .bad_offset_o  (bad_offset_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // literal run token followed by its bytes
  function automatic void add_literals(input logic [BYTE_W-1:0] data[$]);
    stream_q.push_back({NIB_ZERO, 4'(data.size())});
    foreach (data[j]) stream_q.push_back(data[j]);
    gen_produced += data.size();
    if (gen_produced > HIST_DEPTH) gen_produced = HIST_DEPTH;
  endfunction

  // match token and offset byte
  function automatic void add_match(int unsigned len, int unsigned offs);
    logic [OFFS_W-1:0] o;
    o = offs[OFFS_W-1:0];
    stream_q.push_back({len[NIB_W-1:0], o[11:8]});
    stream_q.push_back(o[7:0]);
    if (o != 0 && o <= gen_produced) begin
      gen_produced += len;
      if (gen_produced > HIST_DEPTH) gen_produced = HIST_DEPTH;
    end
  endfunction

  // 0: sender idles lightly, 1: receiver idles lightly, 2 and on: no idling
  function automatic int unsigned idle_phase();
    return (stream_total == 0) ? 0 : sent_count * 3 / stream_total;
  endfunction

  // offers one byte after random idle cycles and waits until it is taken
  task automatic send_byte(input logic [BYTE_W-1:0] b, input int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      in_byte_i  <= 8'($urandom_range(255));
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.decode_byte(b);
    sent_count++;
  endtask

  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!hold_done && stream_total != 0 && sent_count >= stream_total * 2 / 3 + 20) begin
        // long hold-off while the sender keeps offering bytes
        hold_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      case (idle_phase())
        0:       out_stall_i <= ($urandom_range(99) < 72);
        1:       out_stall_i <= ($urandom_range(99) < 24);
        default: out_stall_i <= 1'b0;
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_output(decoded_t'({out_byte_o, byte_valid_o, last_of_run_o, stream_end_o,
                                  bad_offset_o}));
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results pending",
               quiet_cycles, sb.decoded_q.size());
      $display("** lz77_token_decoder: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned       pick, len, reach, idle_pct;
    logic [BYTE_W-1:0] tok;
    logic [BYTE_W-1:0] lit[$];
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_byte_i  <= '0;

    // header, then the corner cases of offsets and runs
    stream_q = '{8'h00, 8'hff, 8'h5a};
    add_match(1, 0);                       // zero offset
    add_match(1, 1);                       // offset before anything was produced
    add_literals('{8'h00, 8'hff, 8'h80});
    add_match(15, 1);                      // fully overlapping copy
    add_match(15, 4095);                   // far beyond the history
    add_match(2, 18);                      // reaches exactly the oldest byte
    add_match(1, 21);                      // one past the oldest byte
    add_literals('{8'h7f, 8'h01});
    add_match(3, 2);

    while (stream_q.size() < RANDOM_ITEMS) begin
      pick  = $urandom_range(99);
      reach = (gen_produced > 4095) ? 4095 : gen_produced;
      if (gen_produced == 0 || pick < 20) begin
        lit.delete();
        repeat ($urandom_range(1, 15)) lit.push_back(8'($urandom_range(255)));
        add_literals(lit);
      end else if (pick < 70) begin
        len = ($urandom_range(3) == 0) ? $urandom_range(1, 15) : $urandom_range(10, 15);
        add_match(len, $urandom_range(1, reach));
      end else if (pick < 85) begin
        add_match($urandom_range(1, 15), $urandom_range(1, (reach > 4) ? 4 : reach));
      end else begin
        // random token, never the end token
        tok = 8'($urandom_range(1, 255));
        if (tok[7:4] == NIB_ZERO) begin
          lit.delete();
          repeat (tok[3:0]) lit.push_back(8'($urandom_range(255)));
          add_literals(lit);
        end else begin
          add_match(tok[7:4], {tok[3:0], 8'($urandom_range(255))});
        end
      end
    end
    stream_q.push_back({NIB_ZERO, NIB_ZERO});
    repeat (3) stream_q.push_back(8'($urandom_range(255)));   // dropped after the end
    stream_total = stream_q.size();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stream_q[k]) begin
      case (idle_phase())
        0:       idle_pct = 24;
        1:       idle_pct = 72;
        default: idle_pct = 0;
      endcase
      send_byte(stream_q[k], idle_pct);
    end
    in_valid_i <= 1'b0;

    while (sb.decoded_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.decoded_q.size() != 0) sb.n_errors++;

    $display("sent %0d stream bytes, checked %0d results: %0d decoded bytes,",
             sent_count, sb.n_checked, sb.n_data);
    $display("%0d rejected offsets, %0d end token, history reach %0d bytes, %0d mismatches",
             sb.n_bad, sb.n_end, sb.produced, sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("** lz77_token_decoder: PASSED **");
    end else begin
      $display("** lz77_token_decoder: FAILED **");
    end
    $finish;
  end

endmodule

// ===== lz77_token_decoder.f =====
+incdir+rtl/core
rtl/core/lztd_pkg.sv
rtl/core/lztd_ram.sv
rtl/core/lztd_ctrl.sv
rtl/core/lztd_out_stage.sv
rtl/core/lz77_token_decoder.sv
tb/testbench.sv
